// ===== rtl/ssq_pkg.sv =====
package ssq_pkg;

   // fixed field widths of the request and response words
   localparam int DATA_W       = 32;
   localparam int PRIO_FIELD_W = 8;
   localparam int FILL_W       = 5;

   // default sizing
   localparam int DEPTH_DEF     = 16;
   localparam int PRIO_BITS_DEF = 8;

   // operation codes
   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_kind_type;

   // request word
   typedef struct packed {
      op_kind_type              kind;
      logic [PRIO_FIELD_W-1:0]  prio;
      logic signed [DATA_W-1:0] data_in;
   } req_word_type;

   // response word
   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic                     was_empty;
      logic                     was_full;
      logic [FILL_W-1:0]        fill_level;
   } rsp_word_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

// ===== rtl/ssq_cell.sv =====
module ssq_cell #(
   parameter int PRIO_BITS = ssq_pkg::PRIO_BITS_DEF,
   parameter int CNT_W     = 5,
   parameter int INDEX     = 0
) (
   input  logic                             clock,
   input  ssq_pkg::cell_ctl_type            ctl,
   input  logic [CNT_W-1:0]                 count,
   input  logic [PRIO_BITS-1:0]             new_prio,
   input  logic signed [ssq_pkg::DATA_W-1:0] new_data,
   input  logic [PRIO_BITS-1:0]             left_prio,
   input  logic signed [ssq_pkg::DATA_W-1:0] left_data,
   input  logic                             left_keep,
   input  logic [PRIO_BITS-1:0]             right_prio,
   input  logic signed [ssq_pkg::DATA_W-1:0] right_data,
   output logic [PRIO_BITS-1:0]             prio,
   output logic signed [ssq_pkg::DATA_W-1:0] data,
   output logic                             keep
);

   logic [PRIO_BITS-1:0]              slot_prio_ff, slot_prio_in;
   logic signed [ssq_pkg::DATA_W-1:0] slot_data_ff, slot_data_in;
   logic                              occupied;

   // this slot holds an entry that stays ahead of the new one
   assign occupied = count > CNT_W'(INDEX);
   assign keep     = occupied && (slot_prio_ff <= new_prio);

   // keep, take the new entry, shift in from the left or from the right
   always_comb begin
      slot_prio_in = slot_prio_ff;
      slot_data_in = slot_data_ff;
      if (ctl.insert) begin
         if (!keep) begin
            if (left_keep) begin
               slot_prio_in = new_prio;
               slot_data_in = new_data;
            end else begin
               slot_prio_in = left_prio;
               slot_data_in = left_data;
            end
         end
      end else if (ctl.remove) begin
         slot_prio_in = right_prio;
         slot_data_in = right_data;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      slot_prio_ff <= slot_prio_in;
      slot_data_ff <= slot_data_in;
   end

   assign prio = slot_prio_ff;
   assign data = slot_data_ff;

endmodule

// ===== rtl/stable_sorted_priority_queue_unit.sv =====
// Stable sorted priority queue.
// Request channel (req_valid, req_stall, req_word): kind selects insert or
// remove head. An insert places its entry behind all held entries of lower
// or equal priority, so equal priorities leave in arrival order; an insert
// into a full queue is dropped and answered with was_full. A remove returns
// the head value, or 0 with was_empty on an empty queue.
// Response channel (rsp_valid, rsp_stall, rsp_word): exactly one word per
// request, carrying the fill level after the operation.
// The response is registered and valid in the cycle after the request is
// accepted. Throughput: one request per cycle unless the response stalls;
// the slots form a row of cells that all compare against the new priority
// in parallel and shift by one slot toward their neighbor in the same cycle.
// Reset clears the entry count and the response valid; slot contents and the
// response payload are left as they are. While the response word is stalled,
// req_stall is raised and the word holds; a new request is taken in the cycle
// the word leaves.
module stable_sorted_priority_queue_unit #(
   parameter int DEPTH     = ssq_pkg::DEPTH_DEF,
   parameter int PRIO_BITS = ssq_pkg::PRIO_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ssq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ssq_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                              accept;
   logic                              full;
   logic                              empty;
   logic                              is_insert;
   logic                              is_remove;
   ssq_pkg::cell_ctl_type             ctl;
   logic [PRIO_BITS-1:0]              new_prio;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ssq_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [PRIO_BITS-1:0]              cell_prio  [DEPTH];
   logic signed [ssq_pkg::DATA_W-1:0] cell_data  [DEPTH];
   logic                              cell_keep  [DEPTH];
   logic [PRIO_BITS-1:0]              left_prio  [DEPTH];
   logic signed [ssq_pkg::DATA_W-1:0] left_data  [DEPTH];
   logic                              left_keep  [DEPTH];
   logic [PRIO_BITS-1:0]              right_prio [DEPTH];
   logic signed [ssq_pkg::DATA_W-1:0] right_data [DEPTH];

   // handshake: take a word when the response register is free or leaving
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // operation decode
   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;
   assign is_insert = req_word.kind == ssq_pkg::OP_INSERT;
   assign is_remove = req_word.kind == ssq_pkg::OP_REMOVE;
   assign new_prio  = PRIO_BITS'(req_word.prio);

   assign ctl.insert = accept && is_insert && !full;
   assign ctl.remove = accept && is_remove && !empty;

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // neighbor wiring and the row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_prio[i] = new_prio;
         assign left_data[i] = req_word.data_in;
         assign left_keep[i] = 1'b1;
      end else begin : g_body
         assign left_prio[i] = cell_prio[i-1];
         assign left_data[i] = cell_data[i-1];
         assign left_keep[i] = cell_keep[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_prio[i] = cell_prio[i];
         assign right_data[i] = cell_data[i];
      end else begin : g_inner
         assign right_prio[i] = cell_prio[i+1];
         assign right_data[i] = cell_data[i+1];
      end

      ssq_cell #(
         .PRIO_BITS (PRIO_BITS),
         .CNT_W     (CNT_W),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .new_prio   (new_prio),
         .new_data   (req_word.data_in),
         .left_prio  (left_prio[i]),
         .left_data  (left_data[i]),
         .left_keep  (left_keep[i]),
         .right_prio (right_prio[i]),
         .right_data (right_data[i]),
         .prio       (cell_prio[i]),
         .data       (cell_data[i]),
         .keep       (cell_keep[i])
      );
   end

   // response word
   always_comb begin
      rsp_word_in.data_out   = ctl.remove ? cell_data[0] : '0;
      rsp_word_in.was_empty  = is_remove && empty;
      rsp_word_in.was_full   = is_insert && full;
      rsp_word_in.fill_level = ssq_pkg::FILL_W'(count_in);
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   // count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // the two head cells stay in priority order
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> cell_prio[0] <= cell_prio[1])
      else $error("head cells out of order");

   // an accepted word is answered next cycle with the updated fill level
   a_fill_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_word_ff.fill_level == ssq_pkg::FILL_W'(count_ff))
      else $error("fill level does not match count");

   // a remove from a non-empty queue never reports empty
   a_remove_hit: assert property (@(posedge clock) disable iff (reset)
      ctl.remove |=> !rsp_word_ff.was_empty && !rsp_word_ff.was_full)
      else $error("remove flagged wrongly");
`endif

endmodule
